@@ src/kts_pkg.sv @@
// Package for the keyed timeout state table: opcodes, record kinds, FSM states.
// Used by kts_scan_unit and keyed_timeout_state_table.
package kts_pkg;
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ADDRESS_BITS_DEF  = 8;
    localparam int TIMEOUT_BITS_DEF  = 16;

    localparam logic [1:0] OP_ADD       = 2'd0;
    localparam logic [1:0] OP_ERASE_KEY = 2'd1;
    localparam logic [1:0] OP_ERASE_ADR = 2'd2;
    localparam logic [1:0] OP_TICK      = 2'd3;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD_DECIDE,
        ST_EMIT_OLD,
        ST_EMIT_NEW,
        ST_TICK_SCAN,
        ST_TICK_PICK,
        ST_TICK_EMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] addr;
        logic [31:0] msg;
        logic [7:0] prio;
        logic       act;
        logic       full;
    } record_t;
endpackage

@@ src/kts_scan_unit.sv @@
// Shared key compare unit for the state table: one slot per cycle.
// Depends on kts_pkg.
module kts_scan_unit #(
    parameter int ADDRESS_BITS = kts_pkg::ADDRESS_BITS_DEF
) (
    input  logic [ADDRESS_BITS-1:0] slot_addr,
    input  logic [31:0]             slot_msg,
    input  logic                    slot_active,
    input  logic [ADDRESS_BITS-1:0] key_addr,
    input  logic [31:0]             key_msg,
    input  logic [ADDRESS_BITS-1:0] best_addr,
    input  logic [31:0]             best_msg,
    output logic                    addr_hit,
    output logic                    key_hit,
    output logic                    less_than_best
);
    assign addr_hit       = slot_active && (slot_addr == key_addr);
    assign key_hit        = addr_hit && (slot_msg == key_msg);
    assign less_than_best = {slot_addr, slot_msg} < {best_addr, best_msg};
endmodule

@@ src/keyed_timeout_state_table.sv @@
// Keyed timeout state table, top level. Depends on kts_pkg and kts_scan_unit.
// Sequence: an item scans the table one slot per cycle, then emits its records one per
// cycle while the output is free; a tick first counts down in a scan of its own, and
// each expiry is then picked by a full scan. Not ready while an item is in work; result
// stalls add cycles. Reset (aresetn low, synchronous) clears active flags and the
// sequencer; key, priority, counter stores are not.
module keyed_timeout_state_table #(
    parameter int TABLE_ENTRIES = kts_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDRESS_BITS  = kts_pkg::ADDRESS_BITS_DEF,
    parameter int TIMEOUT_BITS  = kts_pkg::TIMEOUT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[1:0], source_address[9:2], message_code[41:10], priority_req[49:42],
    // timeout_ticks[65:50], zero fill
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // event_address[7:0], event_message[39:8], event_priority[47:40],
    // event_active[48], table_full[49], zero fill
    output logic [55:0] m_tdata,
    output logic        m_tuser, // record_kind
    output logic        m_tlast
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    logic [ADDRESS_BITS-1:0] mem_addr [TABLE_ENTRIES];
    logic [31:0]             mem_msg  [TABLE_ENTRIES];
    logic [7:0]              mem_prio [TABLE_ENTRIES];
    logic [TIMEOUT_BITS-1:0] mem_cnt  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] active_reg, expire_reg;

    kts_pkg::state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [1:0] op_reg;
    logic [ADDRESS_BITS-1:0] key_addr_reg;
    logic [31:0] key_msg_reg;
    logic [7:0] prio_reg;
    logic [TIMEOUT_BITS-1:0] tmo_reg;
    logic hit_reg, free_reg, best_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg, best_idx_reg;
    logic [ADDRESS_BITS-1:0] best_addr_reg;
    logic [31:0] best_msg_reg;
    logic full_reg;
    kts_pkg::record_t rec_reg;
    logic out_valid_reg;

    logic addr_hit, key_hit, less;
    kts_scan_unit #(.ADDRESS_BITS(ADDRESS_BITS)) u_scan (
        .slot_addr(mem_addr[idx_reg]), .slot_msg(mem_msg[idx_reg]),
        .slot_active(active_reg[idx_reg]), .key_addr(key_addr_reg),
        .key_msg(key_msg_reg), .best_addr(best_addr_reg), .best_msg(best_msg_reg),
        .addr_hit(addr_hit), .key_hit(key_hit), .less_than_best(less)
    );

    logic out_free;
    logic rec_load;
    assign out_free = !out_valid_reg || m_tready;
    assign rec_load = out_free && (state_reg == kts_pkg::ST_EMIT_OLD ||
                                   state_reg == kts_pkg::ST_EMIT_NEW ||
                                   state_reg == kts_pkg::ST_TICK_EMIT ||
                                   state_reg == kts_pkg::ST_DONE);
    assign s_tready = (state_reg == kts_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = rec_reg.kind;
    assign m_tlast  = rec_reg.kind;
    assign m_tdata  = {6'd0, rec_reg.full, rec_reg.act, rec_reg.prio, rec_reg.msg,
                       rec_reg.addr};

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            kts_pkg::ST_IDLE: if (s_tvalid) begin
                idx_next   = '0;
                state_next = (s_tdata[1:0] == kts_pkg::OP_TICK) ?
                             kts_pkg::ST_TICK_SCAN : kts_pkg::ST_SCAN;
            end
            kts_pkg::ST_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                    state_next = (op_reg == kts_pkg::OP_ADD) ?
                                 kts_pkg::ST_ADD_DECIDE : kts_pkg::ST_DONE;
            end
            kts_pkg::ST_ADD_DECIDE:
                state_next = (hit_reg && mem_prio[hit_idx_reg] != prio_reg) ?
                             kts_pkg::ST_EMIT_OLD :
                             (!hit_reg && free_reg) ? kts_pkg::ST_EMIT_NEW :
                             kts_pkg::ST_DONE;
            kts_pkg::ST_EMIT_OLD: if (out_free) state_next = kts_pkg::ST_EMIT_NEW;
            kts_pkg::ST_EMIT_NEW: if (out_free) state_next = kts_pkg::ST_DONE;
            kts_pkg::ST_TICK_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = kts_pkg::ST_TICK_PICK;
                end
            end
            kts_pkg::ST_TICK_PICK: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                    state_next = (best_reg || (expire_reg[idx_reg] &&
                                  (!best_reg || less))) ?
                                 kts_pkg::ST_TICK_EMIT : kts_pkg::ST_DONE;
            end
            kts_pkg::ST_TICK_EMIT: if (out_free) begin
                idx_next   = '0;
                state_next = kts_pkg::ST_TICK_PICK;
            end
            kts_pkg::ST_DONE: if (out_free) state_next = kts_pkg::ST_IDLE;
            default: state_next = kts_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kts_pkg::ST_IDLE;
            idx_reg       <= '0;
            active_reg    <= '0;
            expire_reg    <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            best_reg      <= 1'b0;
            full_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (rec_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                kts_pkg::ST_IDLE: if (s_tvalid) begin
                    op_reg       <= s_tdata[1:0];
                    key_addr_reg <= s_tdata[2 +: ADDRESS_BITS];
                    key_msg_reg  <= s_tdata[41:10];
                    prio_reg     <= s_tdata[49:42];
                    tmo_reg      <= s_tdata[50 +: TIMEOUT_BITS];
                    hit_reg      <= 1'b0;
                    free_reg     <= 1'b0;
                    best_reg     <= 1'b0;
                    full_reg     <= 1'b0;
                end
                kts_pkg::ST_SCAN: begin
                    if (key_hit && !hit_reg) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= idx_reg;
                    end
                    if (!active_reg[idx_reg] && !free_reg) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                    if ((op_reg == kts_pkg::OP_ERASE_KEY && key_hit && !hit_reg) ||
                        (op_reg == kts_pkg::OP_ERASE_ADR && addr_hit))
                        mem_cnt[idx_reg] <= TIMEOUT_BITS'(1);
                end
                kts_pkg::ST_ADD_DECIDE: begin
                    if (hit_reg) begin
                        mem_cnt[hit_idx_reg] <= tmo_reg;
                    end else if (free_reg) begin
                        active_reg[free_idx_reg] <= 1'b1;
                        mem_addr[free_idx_reg]   <= key_addr_reg;
                        mem_msg[free_idx_reg]    <= key_msg_reg;
                        mem_prio[free_idx_reg]   <= prio_reg;
                        mem_cnt[free_idx_reg]    <= tmo_reg;
                    end else begin
                        full_reg <= 1'b1;
                    end
                end
                kts_pkg::ST_EMIT_OLD: if (out_free) begin
                    rec_reg <= '{kind: kts_pkg::KIND_EVENT,
                                 addr: 8'(key_addr_reg), msg: key_msg_reg,
                                 prio: mem_prio[hit_idx_reg], act: 1'b0, full: 1'b0};
                    mem_prio[hit_idx_reg] <= prio_reg;
                end
                kts_pkg::ST_EMIT_NEW: if (out_free) begin
                    rec_reg <= '{kind: kts_pkg::KIND_EVENT,
                                 addr: 8'(key_addr_reg), msg: key_msg_reg,
                                 prio: prio_reg, act: 1'b1, full: 1'b0};
                end
                kts_pkg::ST_TICK_SCAN: if (active_reg[idx_reg]) begin
                    if (mem_cnt[idx_reg] != '0)
                        mem_cnt[idx_reg] <= mem_cnt[idx_reg] - 1'b1;
                    else
                        expire_reg[idx_reg] <= 1'b1;
                end
                kts_pkg::ST_TICK_PICK:
                    if (expire_reg[idx_reg] && (!best_reg || less)) begin
                        best_reg      <= 1'b1;
                        best_idx_reg  <= idx_reg;
                        best_addr_reg <= mem_addr[idx_reg];
                        best_msg_reg  <= mem_msg[idx_reg];
                    end
                kts_pkg::ST_TICK_EMIT: if (out_free) begin
                    rec_reg <= '{kind: kts_pkg::KIND_EVENT,
                                 addr: 8'(mem_addr[best_idx_reg]),
                                 msg: mem_msg[best_idx_reg],
                                 prio: mem_prio[best_idx_reg], act: 1'b0, full: 1'b0};
                    expire_reg[best_idx_reg] <= 1'b0;
                    active_reg[best_idx_reg] <= 1'b0;
                    best_reg <= 1'b0;
                end
                kts_pkg::ST_DONE: if (out_free) begin
                    rec_reg <= '{kind: kts_pkg::KIND_DONE, addr: 8'd0, msg: 32'd0,
                                 prio: 8'd0, act: 1'b0, full: full_reg};
                end
                default: ;
            endcase
        end
    end
endmodule
